@@ rtl/yfra_pkg.sv @@
// shared types, constants and helpers for the yuv frame rmse accumulator
package yfra_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W = 13;
	localparam int SSD_W = 41;
	localparam int CNT_W = 25;
	localparam int RMSE_W = 16;
	localparam int TOTAL_W = 40;
	localparam int FRAMES_W = 24;
	localparam int DIV_W = SSD_W + 16;
	localparam int ROOT_STEPS = 29;
	localparam int DIV_CNT_W = 6;

	// floor(x / 3) as (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2^19
	localparam logic [17:0] DIV3_MUL = 18'd174763;
	localparam int DIV3_SHIFT = 19;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_CHROMA = 2'd2;

	localparam logic [1:0] FMT_420 = 2'd0;
	localparam logic [1:0] FMT_422 = 2'd1;

	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	typedef enum logic [3:0] {
		ST_ACC = 4'b0001,
		ST_DIV = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_OUT = 4'b1000
	} yfra_state_t;

	typedef struct packed {
		logic clear_acc;
		logic start_div;
		logic div_step;
		logic start_root;
		logic root_step;
		logic finish_plane;
	} yfra_cmd_t;

	typedef struct packed {
		logic plane_end;
		logic last_plane;
	} yfra_status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2))
			return DIM_W'(2);
		if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

endpackage

@@ rtl/yfra_ctrl.sv @@
// controller: sequences accumulate, divide, root and output per plane
module yfra_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  yfra_pkg::yfra_status_t status,
	input  logic                   out_free,
	output yfra_pkg::yfra_cmd_t    cmd,
	output logic                   busy
);
	import yfra_pkg::*;

	yfra_state_t state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (in_fire && status.plane_end) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
						state_q <= ST_ROOT;
						cnt_q <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(ROOT_STEPS - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!status.last_plane || out_free)
						state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.start_div = (state_q == ST_ACC) && in_fire && status.plane_end;
		cmd.div_step = (state_q == ST_DIV);
		cmd.start_root = (state_q == ST_DIV) && (cnt_q == DIV_CNT_W'(DIV_W - 1));
		cmd.root_step = (state_q == ST_ROOT);
		cmd.finish_plane = (state_q == ST_OUT) && (!status.last_plane || out_free);
		cmd.clear_acc = cmd.start_div;
	end

	assign busy = (state_q != ST_ACC);
endmodule

@@ rtl/yfra_dp.sv @@
// datapath: ssd accumulation, restoring divider, bit-serial root, frame stats
module yfra_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic [7:0]                     orig_pixel,
	input  logic [7:0]                     eval_pixel,
	input  logic [yfra_pkg::DIM_W-1:0]     frame_width,
	input  logic [yfra_pkg::DIM_W-1:0]     frame_height,
	input  logic [1:0]                     chroma_format,
	input  yfra_pkg::yfra_cmd_t            cmd,
	output yfra_pkg::yfra_status_t         status,
	output logic                           res_load,
	output logic [yfra_pkg::RMSE_W-1:0]    luma_rmse,
	output logic [yfra_pkg::RMSE_W-1:0]    cb_rmse,
	output logic [yfra_pkg::RMSE_W-1:0]    cr_rmse,
	output logic [yfra_pkg::RMSE_W-1:0]    frame_rmse,
	output logic [yfra_pkg::TOTAL_W-1:0]   rmse_total,
	output logic [yfra_pkg::FRAMES_W-1:0]  frames_done
);
	import yfra_pkg::*;

	logic [SSD_W-1:0] ssd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] plane_q;
	logic [RMSE_W-1:0] luma_q, cb_q;
	logic [TOTAL_W-1:0] sum_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [CNT_W-1:0] size_q;
	logic [DIV_W-1:0] num_q, quo_q;
	logic [CNT_W:0] rem_q;
	logic [DIV_W+1:0] rad_q;
	logic [29:0] root_q;
	logic [31:0] racc_q;

	logic [7:0] diff;
	logic [15:0] sq;
	logic [SSD_W-1:0] ssd_next;
	logic [CNT_W-1:0] cnt_next, luma_size, size;
	logic [DIM_W-1:0] w, h;
	logic [CNT_W:0] rem_sh;
	logic [31:0] trial;
	logic [31:0] racc_sh;
	logic [RMSE_W-1:0] rmse;
	logic [RMSE_W+1:0] three_sum;
	logic [35:0] mean_prod;
	logic [RMSE_W-1:0] mean;
	logic [TOTAL_W:0] sum_next;

	assign diff = (orig_pixel > eval_pixel) ? orig_pixel - eval_pixel
		: eval_pixel - orig_pixel;
	assign sq = diff * diff;
	assign ssd_next = ssd_q + SSD_W'(sq);
	assign cnt_next = cnt_q + 1'b1;
	assign w = clamp_dim(frame_width);
	assign h = clamp_dim(frame_height);
	assign luma_size = CNT_W'(w) * CNT_W'(h);

	always_comb begin
		size = luma_size;
		if (plane_q != PLANE_Y) begin
			case (chroma_format)
				FMT_420: size = luma_size >> 2;
				FMT_422: size = CNT_W'(h) * CNT_W'(w >> 1);
				default: size = luma_size;
			endcase
		end
	end

	assign status.plane_end = (cnt_next >= size);
	assign status.last_plane = (plane_q == PLANE_V);

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q[CNT_W-1:0], num_q[DIV_W-1]};
	// bit-serial root, two radicand bits per cycle
	assign racc_sh = {racc_q[29:0], rad_q[DIV_W+1:DIV_W]};
	assign trial = {root_q, 2'b01};
	assign rmse = root_q[RMSE_W-1:0];
	assign three_sum = {2'b00, luma_q} + {2'b00, cb_q} + {2'b00, rmse};
	// divide by three through a reciprocal multiply
	assign mean_prod = 36'(three_sum) * 36'(DIV3_MUL);
	assign mean = mean_prod[DIV3_SHIFT +: RMSE_W];
	assign sum_next = {1'b0, sum_q} + (TOTAL_W+1)'(mean);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssd_q <= '0;
			cnt_q <= '0;
			plane_q <= PLANE_Y;
			luma_q <= '0;
			cb_q <= '0;
			sum_q <= '0;
			frames_q <= '0;
		end else begin
			if (in_fire && !cmd.clear_acc) begin
				ssd_q <= ssd_next;
				cnt_q <= cnt_next;
			end else if (cmd.clear_acc) begin
				ssd_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.finish_plane) begin
				case (plane_q)
					PLANE_Y: begin
						luma_q <= rmse;
						plane_q <= PLANE_U;
					end
					PLANE_U: begin
						cb_q <= rmse;
						plane_q <= PLANE_V;
					end
					default: begin
						plane_q <= PLANE_Y;
						sum_q <= sum_next[TOTAL_W] ? '1 : sum_next[TOTAL_W-1:0];
						if (frames_q != '1)
							frames_q <= frames_q + 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			num_q <= {ssd_next, 16'd0};
			size_q <= size;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, size_q}) begin
				rem_q <= rem_sh - {1'b0, size_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.start_root) begin
			rad_q <= {1'b0, quo_q[DIV_W-2:0],
				(rem_sh >= {1'b0, size_q}) ? 1'b1 : 1'b0, quo_q[DIV_W-1]};
			root_q <= '0;
			racc_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (racc_sh >= trial) begin
				racc_q <= racc_sh - trial;
				root_q <= {root_q[28:0], 1'b1};
			end else begin
				racc_q <= racc_sh;
				root_q <= {root_q[28:0], 1'b0};
			end
		end
	end

	assign res_load = cmd.finish_plane && (plane_q == PLANE_V);
	assign luma_rmse = luma_q;
	assign cb_rmse = cb_q;
	assign cr_rmse = rmse;
	assign frame_rmse = mean;
	assign rmse_total = sum_next[TOTAL_W] ? '1 : sum_next[TOTAL_W-1:0];
	assign frames_done = (frames_q != '1) ? frames_q + 1'b1 : frames_q;
endmodule

@@ rtl/yuv_frame_rmse_accumulator_unit.sv @@
// top level: yuv frame rmse accumulator with stream ports and config port
// a plane-ending word passes through the divide, root and output states in turn
// throughput: one word per cycle inside a plane; input pauses at each plane end
// the divide loop and the bit-serial root set that pause
// output register frees the datapath, but a v plane end waits while it still holds a word
// reset: arst_n clears all counters, sums, plane index and config to defaults
module yuv_frame_rmse_accumulator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [yfra_pkg::DIM_W-1:0]    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // orig_pixel, eval_pixel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// luma_rmse, cb_rmse, cr_rmse, frame_rmse, rmse_total, frames_done
	output logic [127:0]                  m_axis_tdata
);
	import yfra_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [1:0] chroma_q;
	yfra_cmd_t cmd;
	yfra_status_t status;
	logic busy, in_fire, res_load, out_free;
	logic [RMSE_W-1:0] luma_rmse, cb_rmse, cr_rmse, frame_rmse;
	logic [TOTAL_W-1:0] rmse_total;
	logic [FRAMES_W-1:0] frames_done;
	logic out_valid_q;
	logic [127:0] out_data_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(2);
			height_q <= DIM_W'(2);
			chroma_q <= FMT_420;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH: width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_CHROMA: chroma_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input is taken only while accumulating
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	// output slot is free when empty or being drained
	assign out_free = !out_valid_q || m_axis_tready;

	yfra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .status(status),
		.out_free(out_free), .cmd(cmd), .busy(busy)
	);

	yfra_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.orig_pixel(s_axis_tdata[7:0]), .eval_pixel(s_axis_tdata[15:8]),
		.frame_width(width_q), .frame_height(height_q), .chroma_format(chroma_q),
		.cmd(cmd), .status(status), .res_load(res_load),
		.luma_rmse(luma_rmse), .cb_rmse(cb_rmse), .cr_rmse(cr_rmse),
		.frame_rmse(frame_rmse), .rmse_total(rmse_total), .frames_done(frames_done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_data_q <= {frames_done, rmse_total, frame_rmse, cr_rmse,
				cb_rmse, luma_rmse};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
endmodule

@@ tb/sv/yfra_checker.sv @@
// frame rmse predictor and result checker for the yuv frame rmse accumulator
module yfra_checker
	import yfra_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               s_valid,
	input  logic               s_ready,
	input  logic [15:0]        s_data,
	input  logic               m_valid,
	input  logic               m_ready,
	input  logic [127:0]       m_data,
	output int                 mismatches,
	output int                 waiting,
	output int                 frames_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FRAMES_W-1:0] frames;
		logic [TOTAL_W-1:0]  total;
		logic [15:0]         frame_rmse;
		logic [15:0]         cr;
		logic [15:0]         cb;
		logic [15:0]         luma;
	} frame_result_t;

	frame_result_t expected_frames[$];

	logic [DIM_W-1:0]    width_reg, height_reg;
	logic [1:0]          format_reg;
	logic [SSD_W-1:0]    ssd;
	logic [CNT_W-1:0]    count;
	logic [1:0]          plane;
	logic [15:0]         luma_held, cb_held;
	logic [TOTAL_W-1:0]  total;
	logic [FRAMES_W-1:0] frames;

	function automatic longint unsigned dim_limit(logic [DIM_W-1:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// plane size follows the live registers, as the block does
	function automatic longint unsigned plane_len();
		longint unsigned w, h;
		w = dim_limit(width_reg);
		h = dim_limit(height_reg);
		if (plane == PLANE_Y)
			return w * h;
		if (format_reg == FMT_420)
			return (w * h) / 4;
		if (format_reg == FMT_422)
			return h * (w / 2);
		return w * h;
	endfunction

	// floor of 256 * sqrt(sum / n), by bitwise integer root
	function automatic logic [15:0] rmse_of(logic [SSD_W-1:0] s, longint unsigned n);
		longint unsigned q, r, t;
		q = (64'(s) << 16) / n;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= q)
				r = t;
		end
		return r[15:0];
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("frame %0d: %s got %0h want %0h", frames_checked, what, got, want);
		mismatches++;
	endtask

	task automatic absorb_pixel(logic [7:0] a, logic [7:0] b);
		logic [7:0]      d;
		longint unsigned n;
		logic [15:0]     r;
		logic [17:0]     mean;
		logic [TOTAL_W:0] t;
		frame_result_t   e;
		d = (a > b) ? a - b : b - a;
		ssd = ssd + SSD_W'(d) * SSD_W'(d);
		count = count + 1'b1;
		n = plane_len();
		if (count < n)
			return;
		r = rmse_of(ssd, n);
		ssd = '0;
		count = '0;
		case (plane)
			PLANE_Y: begin
				luma_held = r;
				plane = PLANE_U;
			end
			PLANE_U: begin
				cb_held = r;
				plane = PLANE_V;
			end
			default: begin
				plane = PLANE_Y;
				mean = (18'(luma_held) + 18'(cb_held) + 18'(r)) / 3;
				t = {1'b0, total} + (TOTAL_W + 1)'(mean);
				total = t[TOTAL_W] ? '1 : t[TOTAL_W-1:0];
				if (frames != '1)
					frames = frames + 1'b1;
				e.luma = luma_held;
				e.cb = cb_held;
				e.cr = r;
				e.frame_rmse = mean[15:0];
				e.total = total;
				e.frames = frames;
				expected_frames.push_back(e);
			end
		endcase
	endtask

	task automatic compare_frame(frame_result_t got);
		frame_result_t want;
		if (expected_frames.size() == 0) begin
			report("unexpected word, tdata", got, 0);
			return;
		end
		want = expected_frames.pop_front();
		if (got.luma != want.luma)
			report("luma_rmse", got.luma, want.luma);
		if (got.cb != want.cb)
			report("cb_rmse", got.cb, want.cb);
		if (got.cr != want.cr)
			report("cr_rmse", got.cr, want.cr);
		if (got.frame_rmse != want.frame_rmse)
			report("frame_rmse", got.frame_rmse, want.frame_rmse);
		if (got.total != want.total)
			report("rmse_total", got.total, want.total);
		if (got.frames != want.frames)
			report("frames_done", got.frames, want.frames);
		frames_checked++;
	endtask

	initial begin
		mismatches = 0;
		frames_checked = 0;
		waiting = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 2;
			height_reg = 2;
			format_reg = FMT_420;
			ssd = '0;
			count = '0;
			plane = PLANE_Y;
			luma_held = '0;
			cb_held = '0;
			total = '0;
			frames = '0;
			expected_frames.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_reg = cfg_data;
					CFG_HEIGHT: height_reg = cfg_data;
					CFG_CHROMA: format_reg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_valid && s_ready)
				absorb_pixel(s_data[7:0], s_data[15:8]);
			if (m_valid && m_ready)
				compare_frame(m_data);
		end
		waiting = expected_frames.size();
	end

endmodule

@@ tb/sv/tb.sv @@
// stimulus and verdict for the yuv frame rmse accumulator
module tb;
	import yfra_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [DIM_W-1:0]   cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [15:0]        s_axis_tdata;   // orig_pixel, eval_pixel
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// luma_rmse, cb_rmse, cr_rmse, frame_rmse, rmse_total, frames_done
	logic [127:0]       m_axis_tdata;

	int mismatches, waiting, frames_checked;
	int words_sent, settings_used;
	// set while neither side may idle
	logic steady;

	yuv_frame_rmse_accumulator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	yfra_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.s_data(s_axis_tdata),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_data(m_axis_tdata),
		.mismatches(mismatches),
		.waiting(waiting),
		.frames_checked(frames_checked)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// result side stalls about a quarter of the time, never in the steady stretch
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 26);
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("yuv_frame_rmse_accumulator_unit: mismatch");
		$finish;
	end

	// words per frame for given raw register values, used only to size stimulus
	function automatic int frame_words(int w, int h, int fmt);
		int cw, ch, luma;
		cw = (w < 2) ? 2 : (w > MAX_DIM) ? MAX_DIM : w;
		ch = (h < 2) ? 2 : (h > MAX_DIM) ? MAX_DIM : h;
		luma = cw * ch;
		if (fmt == FMT_420)
			return luma + 2 * (luma / 4);
		if (fmt == FMT_422)
			return luma + 2 * (ch * (cw / 2));
		return 3 * luma;
	endfunction

	// one word, with a random idle gap in front of it outside the steady stretch
	task automatic send_word(logic [7:0] orig, logic [7:0] eval);
		while (!steady && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {eval, orig};
		do
			@(posedge clk);
		while (!s_axis_tready);
		words_sent++;
	endtask

	// sample pair with a bias toward small errors and exact matches
	task automatic send_random_word();
		logic [7:0] a, b;
		a = $urandom_range(255);
		case ($urandom_range(3))
			0: b = a;
			1: b = a + 8'($urandom_range(6)) - 8'd3;
			default: b = $urandom_range(255);
		endcase
		send_word(a, b);
	endtask

	// drain all frame results, then let a pending plane-end computation finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// block is idle here: program all three registers
	task automatic program_frame(int w, int h, int fmt);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= DIM_W'(w);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= DIM_W'(h);
		@(posedge clk);
		cfg_index <= CFG_CHROMA;
		cfg_data <= DIM_W'(fmt);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// whole frames of random content, optionally cut off mid-frame
	task automatic run_setting(int w, int h, int fmt, int nframes, int tail);
		program_frame(w, h, fmt);
		repeat (nframes * frame_words(w, h, fmt) + tail)
			send_random_word();
		drain();
	endtask

	initial begin
		int random_words, w, h, fmt, n, tail;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		steady = 1'b0;
		words_sent = 0;
		settings_used = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config is 2x2 420: six words per frame
		// worst errors both ways, zero error and alternating bits
		send_word(8'h00, 8'hff);
		send_word(8'hff, 8'h00);
		send_word(8'h00, 8'h00);
		send_word(8'hff, 8'hff);
		send_word(8'h55, 8'haa);
		send_word(8'haa, 8'h55);
		// a perfect frame
		repeat (6) send_word(8'h80, 8'h80);
		// error of one everywhere
		repeat (6) send_word(8'h01, 8'h00);
		repeat (6) send_random_word();
		drain();

		// clamping of both dimensions at both ends, every chroma format
		// a huge clamped plane stays open, the next small setting closes it
		run_setting(8191, 1, FMT_420, 0, 40);
		run_setting(0, 1, FMT_422, 1, 0);
		run_setting(1, 8191, FMT_420, 0, 40);
		run_setting(3, 5, FMT_422, 2, 0);
		run_setting(5, 3, 3, 2, 0);
		run_setting(2, 2, 2, 2, 0);
		// stop mid-plane, then shrink the frame under the running count
		run_setting(6, 6, FMT_420, 1, 20);
		run_setting(2, 2, FMT_420, 2, 0);

		random_words = 0;
		while (random_words < 1200) begin
			steady = (random_words >= 500 && random_words < 800);
			w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
			h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
			fmt = $urandom_range(3);
			n = $urandom_range(1, 3);
			tail = ($urandom_range(4) == 0) ? $urandom_range(1, frame_words(w, h, fmt) - 1) : 0;
			run_setting(w, h, fmt, n, tail);
			random_words += n * frame_words(w, h, fmt) + tail;
		end
		steady = 1'b0;

		$display("sent %0d words over %0d register settings, checked %0d frame results",
			words_sent, settings_used, frames_checked);
		$display("dimensions clamped at both ends, all chroma codes, mid-plane resizes");
		if (mismatches == 0) begin
			$display("yuv_frame_rmse_accumulator_unit: match");
		end else begin
			$display("yuv_frame_rmse_accumulator_unit: mismatch");
		end
		$finish;
	end

endmodule
